>>> rtl/cbd_pkg.sv
`timescale 1ns / 1ps
// Package for the channel breakout detector: widths, register map, controller states
// and the command/status structs between controller and datapath. No dependencies.

package cbd_pkg;

    localparam int PRICE_W = 32;
    localparam int WIN_W   = 7;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [WIN_W-1:0] WIN_RESET = 7'd20;

    // register index = paddr[APB_AW-1:2]
    localparam logic [APB_AW-3:0] REG_WINDOW = 1'b0;

    typedef logic signed [PRICE_W-1:0] t_price;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic win_ready;
        logic walk_last;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/cbd_bar_if.sv
`timescale 1ns / 1ps
// Bar input channel: valid/ready handshake carrying high, low and close.
// Depends on cbd_pkg.

interface cbd_bar_if;
    logic            valid;
    logic            ready;
    cbd_pkg::t_price bar_high;
    cbd_pkg::t_price bar_low;
    cbd_pkg::t_price bar_close;

    modport source (output valid, output bar_high, output bar_low, output bar_close,
                    input ready);
    modport sink   (input valid, input bar_high, input bar_low, input bar_close,
                    output ready);
endinterface

>>> rtl/cbd_res_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying the breakout flags.
// No dependencies.

interface cbd_res_if;
    logic valid;
    logic ready;
    logic bullish_breakout;
    logic bearish_breakout;
    logic window_ready;

    modport source (output valid, output bullish_breakout, output bearish_breakout,
                    output window_ready, input ready);
    modport sink   (input valid, input bullish_breakout, input bearish_breakout,
                    input window_ready, output ready);
endinterface

>>> rtl/cbd_ctrl.sv
`timescale 1ns / 1ps
// Controller FSM: accepts a bar word, sequences the ring walk and the final write.
// Depends on cbd_pkg.

module cbd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cbd_pkg::t_sts i_sts,
    output cbd_pkg::t_cmd o_cmd
);

    cbd_pkg::t_state r_state;
    cbd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cbd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.win_ready ? cbd_pkg::S_WALK : cbd_pkg::S_WRITE;
                end
            end
            cbd_pkg::S_WALK: begin
                if (i_sts.walk_last) begin
                    n_state = cbd_pkg::S_DRAIN;
                end
            end
            cbd_pkg::S_DRAIN: begin
                n_state = cbd_pkg::S_WRITE;
            end
            cbd_pkg::S_WRITE: begin
                if (i_sts.out_free) begin
                    n_state = cbd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cbd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.rd_en  = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            cbd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            cbd_pkg::S_WALK: begin
                o_cmd.rd_en = 1'b1;
            end
            cbd_pkg::S_DRAIN: begin
            end
            cbd_pkg::S_WRITE: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/cbd_dpath.sv
`timescale 1ns / 1ps
// Datapath: bar registers, high/low ring memory, running max/min, counters and the
// output register. Depends on cbd_pkg; driven by cbd_ctrl.

module cbd_dpath #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cbd_pkg::t_cmd               i_cmd,
    output cbd_pkg::t_sts               o_sts,
    input  logic [cbd_pkg::WIN_W-1:0]   i_window,
    input  cbd_pkg::t_price             i_bar_high,
    input  cbd_pkg::t_price             i_bar_low,
    input  cbd_pkg::t_price             i_bar_close,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_bull,
    output logic                        o_bear,
    output logic                        o_win_ready
);

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (CNT_W > cbd_pkg::WIN_W) ? CNT_W : cbd_pkg::WIN_W;
    localparam int PW     = cbd_pkg::PRICE_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_WINDOW - 1);
    localparam logic [CMP_W-1:0]  MAX_EXT   = CMP_W'(MAX_WINDOW);
    localparam cbd_pkg::t_price   PRICE_MIN = {1'b1, {(PW-1){1'b0}}};
    localparam cbd_pkg::t_price   PRICE_MAX = {1'b0, {(PW-1){1'b1}}};

    logic [2*PW-1:0]      mem [MAX_WINDOW];
    logic [2*PW-1:0]      r_rd_data;
    logic                 r_acc_vld;
    logic [SLOT_W-1:0]    r_wr_slot;
    logic [SLOT_W-1:0]    r_rd_slot;
    logic [CNT_W-1:0]     r_bars_seen;
    logic [CMP_W-1:0]     r_walk_cnt;
    cbd_pkg::t_price      r_high;
    cbd_pkg::t_price      r_low;
    cbd_pkg::t_price      r_close;
    cbd_pkg::t_price      r_max;
    cbd_pkg::t_price      r_min;
    logic                 r_win_ready;
    logic                 r_out_valid;
    logic                 r_bull;
    logic                 r_bear;
    logic                 r_rdy;

    logic [CMP_W-1:0]     w_ext;
    logic [CMP_W-1:0]     eff_win;
    cbd_pkg::t_price      rd_high;
    cbd_pkg::t_price      rd_low;

    function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] s);
        prev_slot = (s == '0) ? LAST_SLOT : s - 1'b1;
    endfunction

    // window of zero means one, above the ring depth means the whole ring
    always_comb begin
        w_ext = CMP_W'(i_window);
        if (w_ext == '0) begin
            eff_win = CMP_W'(1);
        end else if (w_ext > MAX_EXT) begin
            eff_win = MAX_EXT;
        end else begin
            eff_win = w_ext;
        end
    end

    assign o_sts.win_ready = CMP_W'(r_bars_seen) >= eff_win;
    assign o_sts.walk_last = r_walk_cnt == (eff_win - 1'b1);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign rd_high = r_rd_data[2*PW-1:PW];
    assign rd_low  = r_rd_data[PW-1:0];

    // ring: written once per bar after the walk, read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            mem[r_wr_slot] <= {r_high, r_low};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[r_rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_high      <= i_bar_high;
            r_low       <= i_bar_low;
            r_close     <= i_bar_close;
            r_win_ready <= o_sts.win_ready;
            r_rd_slot   <= prev_slot(r_wr_slot);
            r_walk_cnt  <= '0;
            r_max       <= PRICE_MIN;
            r_min       <= PRICE_MAX;
        end else begin
            if (i_cmd.rd_en) begin
                r_rd_slot  <= prev_slot(r_rd_slot);
                r_walk_cnt <= r_walk_cnt + 1'b1;
            end
            if (r_acc_vld) begin
                if (rd_high > r_max) begin
                    r_max <= rd_high;
                end
                if (rd_low < r_min) begin
                    r_min <= rd_low;
                end
            end
        end
        if (i_cmd.finish) begin
            r_bull <= r_win_ready && (r_close > r_max);
            r_bear <= r_win_ready && (r_close < r_min);
            r_rdy  <= r_win_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld   <= 1'b0;
            r_wr_slot   <= '0;
            r_bars_seen <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc_vld <= i_cmd.rd_en;
            if (i_cmd.finish) begin
                r_wr_slot <= (r_wr_slot == LAST_SLOT) ? '0 : r_wr_slot + 1'b1;
                if (r_bars_seen != CNT_W'(MAX_WINDOW)) begin
                    r_bars_seen <= r_bars_seen + 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bull      = r_bull;
    assign o_bear      = r_bear;
    assign o_win_ready = r_rdy;

    a_bars_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bars_seen <= CNT_W'(MAX_WINDOW))
        else $error("bars_seen past ring depth");

    a_slot_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.finish |=> $stable(r_wr_slot))
        else $error("write slot moved without a ring write");

    a_no_flag_unready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && !r_win_ready |=> !r_bull && !r_bear && !r_rdy)
        else $error("breakout flagged before window filled");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> r_walk_cnt < eff_win)
        else $error("ring walk overran the window");

endmodule

>>> rtl/channel_breakout_detector.sv
`timescale 1ns / 1ps
// Top level of the channel breakout detector: APB window register, controller and
// datapath. Depends on cbd_pkg, cbd_bar_if, cbd_res_if, cbd_ctrl, cbd_dpath.
//
//   port    dir  handshake     word
//   i_bar   in   valid/ready   bar_high, bar_low, bar_close (signed 32)
//   o_res   out  valid/ready   bullish_breakout, bearish_breakout, window_ready
//   APB     in   psel/penable  window_length at byte address 0
//
// Once the window is filled, a bar walks the ring and drains before its write; until
// then both are skipped. The walk reads one ring entry per cycle from a single-port
// memory. Synchronous active-low reset clears state, counters and window (20).
// A finished word waits in the output register; the next bar is accepted meanwhile
// and stalls in its write step only while that register is still full.

module channel_breakout_detector #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cbd_bar_if.sink                      i_bar,
    cbd_res_if.source                    o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cbd_pkg::APB_AW-1:0]   paddr,
    input  logic [cbd_pkg::APB_DW-1:0]   pwdata,
    output logic [cbd_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    logic [cbd_pkg::WIN_W-1:0] r_window;
    logic                      reg_hit;
    cbd_pkg::t_cmd             cmd;
    cbd_pkg::t_sts             sts;

    assign pready  = 1'b1;
    assign reg_hit = paddr[cbd_pkg::APB_AW-1:2] == cbd_pkg::REG_WINDOW;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= cbd_pkg::WIN_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_window <= pwdata[cbd_pkg::WIN_W-1:0];
        end
    end

    assign prdata = reg_hit ? cbd_pkg::APB_DW'(r_window) : '0;

    cbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_bar.valid),
        .o_in_ready (i_bar.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cbd_dpath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_window    (r_window),
        .i_bar_high  (i_bar.bar_high),
        .i_bar_low   (i_bar.bar_low),
        .i_bar_close (i_bar.bar_close),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_bull      (o_res.bullish_breakout),
        .o_bear      (o_res.bearish_breakout),
        .o_win_ready (o_res.window_ready)
    );

endmodule
